// File: hdl/cfcl_pkg.sv
package cfcl_pkg;

    // command codes on the input tuser
    localparam logic [1:0] CMD_SEND    = 2'd0;
    localparam logic [1:0] CMD_RX      = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    // result kinds on the output tuser
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // reply status codes
    localparam logic [2:0] ST_ACK_ONLY  = 3'd0;
    localparam logic [2:0] ST_DATA_OK   = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_CSUM_FAIL = 3'd3;
    localparam logic [2:0] ST_NO_REPLY  = 3'd4;

    // receive parser phases
    localparam logic [1:0] PH_WAIT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    // frame bytes
    localparam logic [7:0] SYNC_BYTE     = 8'hA5;
    localparam logic [7:0] ACK_BYTE      = 8'h06;
    localparam logic [7:0] OP_READ_D     = 8'h44;
    localparam logic [7:0] OP_READ_R     = 8'h52;
    localparam logic [7:0] OP_READ_N     = 8'h4E;
    localparam logic [7:0] HDR_EXTRA     = 8'd3;
    localparam logic [7:0] OP_INDEX      = 8'd3;
    localparam logic [7:0] IDX_MAX       = 8'hFF;
    localparam logic [7:0] MIN_REPLY_LEN = 8'd4;
    localparam logic [7:0] REPLY_LEN_RST = 8'd11;

    // result buffer sizing
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [2:0] status;
        logic [7:0] data_count;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [CNT_W-1:0]               n;
        t_result [MAX_RESULTS-1:0]      r;
    } t_result_set;

    function automatic t_result mk_result(input logic [1:0] kind,
                                          input logic [7:0] byte_value,
                                          input logic [2:0] status,
                                          input logic [7:0] data_count);
        t_result res;
        res.kind       = kind;
        res.byte_value = byte_value;
        res.status     = status;
        res.data_count = data_count;
        res.last       = 1'b0;
        return res;
    endfunction

endpackage

// File: hdl/cfcl_core.sv
module cfcl_core
    import cfcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_payload_length,
    input  logic        i_payload_last,
    input  logic        i_cfg_write,
    input  logic [7:0]  i_cfg_data,
    output t_result_set o_results
);

    logic [7:0] r_reply_len, n_reply_len;
    logic [7:0] r_tx_csum, n_tx_csum;
    logic [7:0] r_pidx, n_pidx;
    logic       r_read_exp, n_read_exp;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_rx_csum, n_rx_csum;
    logic [7:0] r_rx_count, n_rx_count;
    logic [7:0] r_rx_len, n_rx_len;

    logic       first_byte;
    logic [7:0] len_byte;
    logic [7:0] tx_sum;
    logic [7:0] rx_cnt_inc;
    logic [7:0] data_len;
    t_result_set res;

    // next state and the results of one item
    always_comb begin
        n_reply_len = i_cfg_write ? i_cfg_data : r_reply_len;
        n_tx_csum   = r_tx_csum;
        n_pidx      = r_pidx;
        n_read_exp  = r_read_exp;
        n_phase     = r_phase;
        n_rx_csum   = r_rx_csum;
        n_rx_count  = r_rx_count;
        n_rx_len    = r_rx_len;
        res         = '0;

        first_byte = (r_pidx == 8'd0);
        len_byte   = i_payload_length + HDR_EXTRA;
        tx_sum     = (first_byte ? (SYNC_BYTE + len_byte) : r_tx_csum) + i_data_byte;
        rx_cnt_inc = r_rx_count + 8'd1;
        data_len   = r_rx_len - HDR_EXTRA;

        case (i_command)
            CMD_SEND: begin
                n_tx_csum = tx_sum;
                if (first_byte) begin
                    n_phase    = PH_WAIT;
                    n_rx_csum  = 8'd0;
                    n_rx_count = 8'd0;
                    n_rx_len   = 8'd0;
                    n_read_exp = 1'b0;
                end
                if (r_pidx == OP_INDEX) begin
                    n_read_exp = (i_data_byte == OP_READ_D) || (i_data_byte == OP_READ_R)
                              || (i_data_byte == OP_READ_N);
                end
                n_pidx = (r_pidx != IDX_MAX) ? r_pidx + 8'd1 : r_pidx;
                if (i_payload_last) begin
                    n_pidx = 8'd0;
                end
                if (first_byte) begin
                    res.r[0] = mk_result(KIND_TX, SYNC_BYTE, ST_ACK_ONLY, 8'd0);
                    res.r[1] = mk_result(KIND_TX, len_byte, ST_ACK_ONLY, 8'd0);
                    res.r[2] = mk_result(KIND_TX, i_data_byte, ST_ACK_ONLY, 8'd0);
                    res.r[3] = mk_result(KIND_TX, tx_sum, ST_ACK_ONLY, 8'd0);
                    res.n    = i_payload_last ? CNT_W'(4) : CNT_W'(3);
                end else begin
                    res.r[0] = mk_result(KIND_TX, i_data_byte, ST_ACK_ONLY, 8'd0);
                    res.r[1] = mk_result(KIND_TX, tx_sum, ST_ACK_ONLY, 8'd0);
                    res.n    = i_payload_last ? CNT_W'(2) : CNT_W'(1);
                end
            end
            CMD_RX: begin
                case (r_phase)
                    PH_WAIT: begin
                        if (i_data_byte == ACK_BYTE) begin
                            if (r_read_exp) begin
                                n_phase = PH_LEN;
                            end else begin
                                res.r[0] = mk_result(KIND_STATUS, 8'd0, ST_ACK_ONLY, 8'd0);
                                res.n    = CNT_W'(1);
                            end
                        end
                    end
                    PH_LEN: begin
                        if (i_data_byte != r_reply_len || i_data_byte < MIN_REPLY_LEN) begin
                            n_phase  = PH_WAIT;
                            res.r[0] = mk_result(KIND_STATUS, 8'd0, ST_BAD_LEN, 8'd0);
                            res.n    = CNT_W'(1);
                        end else begin
                            n_rx_len   = i_data_byte;
                            n_rx_count = 8'd0;
                            n_rx_csum  = ACK_BYTE + i_data_byte;
                            n_phase    = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        res.r[0]   = mk_result(KIND_DATA, i_data_byte, ST_ACK_ONLY, 8'd0);
                        res.n      = CNT_W'(1);
                        n_rx_csum  = r_rx_csum + i_data_byte;
                        n_rx_count = rx_cnt_inc;
                        if (rx_cnt_inc >= data_len) begin
                            n_phase = PH_SUM;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                        res.n   = CNT_W'(1);
                        if (r_rx_csum == i_data_byte) begin
                            res.r[0] = mk_result(KIND_STATUS, 8'd0, ST_DATA_OK, data_len);
                        end else begin
                            res.r[0] = mk_result(KIND_STATUS, 8'd0, ST_CSUM_FAIL, 8'd0);
                        end
                    end
                endcase
            end
            CMD_TIMEOUT: begin
                n_phase  = PH_WAIT;
                res.r[0] = mk_result(KIND_STATUS, 8'd0, ST_NO_REPLY, 8'd0);
                res.n    = CNT_W'(1);
            end
            default: begin
                res.n = '0;
            end
        endcase

        // mark the final result of the item
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res.r[i].last = (CNT_W'(i + 1) == res.n);
        end
    end

    assign o_results = res;

    // state registers: framing and parser state update on an accepted item, the reply length on a config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_len <= REPLY_LEN_RST;
            r_tx_csum   <= 8'd0;
            r_pidx      <= 8'd0;
            r_read_exp  <= 1'b0;
            r_phase     <= PH_WAIT;
            r_rx_csum   <= 8'd0;
            r_rx_count  <= 8'd0;
            r_rx_len    <= 8'd0;
        end else begin
            r_reply_len <= n_reply_len;
            if (i_accept) begin
                r_tx_csum  <= n_tx_csum;
                r_pidx     <= n_pidx;
                r_read_exp <= n_read_exp;
                r_phase    <= n_phase;
                r_rx_csum  <= n_rx_csum;
                r_rx_count <= n_rx_count;
                r_rx_len   <= n_rx_len;
            end
        end
    end

endmodule

// File: hdl/cfcl_out_buf.sv
module cfcl_out_buf
    import cfcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result_set i_results,
    input  logic        i_out_ready,
    output logic        o_free,
    output logic        o_out_valid,
    output t_result     o_out
);

    t_result [MAX_RESULTS-1:0] r_res;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [IDX_W-1:0]          r_rd, n_rd;
    logic                      pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out       = r_res[r_rd];
    assign pop         = o_out_valid && i_out_ready;
    // free once the last held result leaves in this cycle
    assign o_free      = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && i_out_ready);

    // read pointer and remaining count
    always_comb begin
        n_cnt = r_cnt;
        n_rd  = r_rd;
        if (i_load) begin
            n_cnt = i_results.n;
            n_rd  = '0;
        end else if (pop) begin
            n_cnt = r_cnt - CNT_W'(1);
            n_rd  = r_rd + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_rd  <= n_rd;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_results.r;
        end
    end

endmodule

// File: hdl/checksummed_command_frame_link.sv
// Command frame link: frames outgoing command payload bytes and parses replies.
// Input channel s_axis: tuser carries the command (send byte, received byte,
// timeout), tdata the data byte and the payload length, tlast the final
// payload byte of a command.
// Output channel m_axis: tuser carries the result kind (transmit byte, reply
// data byte, status), tdata the byte, status code and data count, tlast the
// final result of one input item.
// Config channel: one write sets the expected reply length; it is always
// ready. The user must see that it is written only while the link is idle;
// the link itself does not enforce this.
// The first result of an item is registered and appears in the cycle after
// acceptance. An item leads to zero to four results, and one leaves per
// cycle while the receiver is ready. A new item is taken in the cycle in
// which the last held result leaves, or whenever the buffer is empty.
// Reset clears the framing and parser state, empties the result buffer and
// sets the expected reply length to 11.
// When the receiver stalls, the result buffer holds and s_axis_tready stays
// low until the remaining results have been taken.
module checksummed_command_frame_link
    import cfcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte [7:0], payload_length [15:8]
    input  logic        s_axis_tlast,
    input  logic [1:0]  s_axis_tuser,   // command [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // byte_value [7:0], status [10:8],
                                        // data_count [18:11], zero [23:19]
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser,   // kind [1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    logic        accept;
    logic        buf_free;
    t_result_set results;
    t_result     out_res;

    assign s_axis_tready = buf_free;
    assign accept        = s_axis_tvalid && buf_free;
    assign o_cfg_ready   = 1'b1;

    // framing and reply parsing
    cfcl_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_command        (s_axis_tuser),
        .i_data_byte      (s_axis_tdata[7:0]),
        .i_payload_length (s_axis_tdata[15:8]),
        .i_payload_last   (s_axis_tlast),
        .i_cfg_write      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .o_results        (results)
    );

    // result buffer, one result per cycle while the receiver is ready
    cfcl_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_results   (results),
        .i_out_ready (m_axis_tready),
        .o_free      (buf_free),
        .o_out_valid (m_axis_tvalid),
        .o_out       (out_res)
    );

    // output packing
    assign m_axis_tdata = {5'd0, out_res.data_count, out_res.status, out_res.byte_value};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last;

endmodule

// File: tb/checksummed_command_frame_link_tb.sv
module checksummed_command_frame_link_tb;
    import cfcl_pkg::*;

    // one input item as it travels on s_axis
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic [7:0] plen;
        logic       plast;
    } link_item_t;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // data_byte [7:0], payload_length [15:8]
    logic        s_axis_tlast = 1'b0;
    logic [1:0]  s_axis_tuser = '0;   // command [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // byte_value [7:0], status [10:8],
                                      // data_count [18:11], zero [23:19]
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;        // kind [1:0]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    // stimulus and expectation stores
    link_item_t cmd_items[$];
    t_result    due_results[$];
    int         items_queued = 0;
    int         items_taken = 0;
    int         items_offered = 0;
    int         results_seen = 0;
    int         cfg_writes = 0;
    int         err_count = 0;

    // idling controls
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    // predictor copy of the link state
    logic [7:0] reply_len_cfg = REPLY_LEN_RST;
    logic [7:0] tx_sum;
    logic [7:0] pay_idx;
    logic       read_cmd;
    logic [1:0] rx_ph;
    logic [7:0] rx_sum;
    logic [7:0] rx_cnt;
    logic [7:0] rx_len;

    checksummed_command_frame_link uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_result one_result(input logic [1:0] kind, input logic [7:0] val,
                                           input logic [2:0] st, input logic [7:0] cnt);
        t_result r;
        r.kind       = kind;
        r.byte_value = val;
        r.status     = st;
        r.data_count = cnt;
        r.last       = 1'b0;
        return r;
    endfunction

    // framing and reply parsing for one accepted item
    task automatic predict_link_step(input logic [1:0] cmd, input logic [7:0] b,
                                     input logic [7:0] plen, input logic plast);
        t_result    fr[$];
        logic [7:0] lb;
        case (cmd)
            CMD_SEND: begin
                if (pay_idx == 8'd0) begin
                    lb = plen + HDR_EXTRA;
                    rx_ph = PH_WAIT;
                    rx_sum = '0;
                    rx_cnt = '0;
                    rx_len = '0;
                    read_cmd = 1'b0;
                    fr.push_back(one_result(KIND_TX, SYNC_BYTE, ST_ACK_ONLY, 8'd0));
                    fr.push_back(one_result(KIND_TX, lb, ST_ACK_ONLY, 8'd0));
                    tx_sum = SYNC_BYTE + lb;
                end
                if (pay_idx == OP_INDEX)
                    read_cmd = (b == OP_READ_D || b == OP_READ_R || b == OP_READ_N);
                fr.push_back(one_result(KIND_TX, b, ST_ACK_ONLY, 8'd0));
                tx_sum = tx_sum + b;
                if (pay_idx < IDX_MAX)
                    pay_idx = pay_idx + 8'd1;
                if (plast) begin
                    fr.push_back(one_result(KIND_TX, tx_sum, ST_ACK_ONLY, 8'd0));
                    pay_idx = '0;
                end
            end
            CMD_RX: begin
                case (rx_ph)
                    PH_WAIT: begin
                        if (b == ACK_BYTE) begin
                            if (read_cmd)
                                rx_ph = PH_LEN;
                            else
                                fr.push_back(one_result(KIND_STATUS, 8'd0, ST_ACK_ONLY, 8'd0));
                        end
                    end
                    PH_LEN: begin
                        if (b != reply_len_cfg || b < MIN_REPLY_LEN) begin
                            rx_ph = PH_WAIT;
                            fr.push_back(one_result(KIND_STATUS, 8'd0, ST_BAD_LEN, 8'd0));
                        end else begin
                            rx_len = b;
                            rx_cnt = '0;
                            rx_sum = ACK_BYTE + b;
                            rx_ph = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        fr.push_back(one_result(KIND_DATA, b, ST_ACK_ONLY, 8'd0));
                        rx_sum = rx_sum + b;
                        rx_cnt = rx_cnt + 8'd1;
                        if (rx_cnt >= rx_len - HDR_EXTRA)
                            rx_ph = PH_SUM;
                    end
                    default: begin
                        rx_ph = PH_WAIT;
                        if (rx_sum == b)
                            fr.push_back(one_result(KIND_STATUS, 8'd0, ST_DATA_OK,
                                                    rx_len - HDR_EXTRA));
                        else
                            fr.push_back(one_result(KIND_STATUS, 8'd0, ST_CSUM_FAIL, 8'd0));
                    end
                endcase
            end
            CMD_TIMEOUT: begin
                rx_ph = PH_WAIT;
                fr.push_back(one_result(KIND_STATUS, 8'd0, ST_NO_REPLY, 8'd0));
            end
            default: ;
        endcase
        if (fr.size() > 0)
            fr[fr.size() - 1].last = 1'b1;
        foreach (fr[i])
            due_results.push_back(fr[i]);
    endtask

    function automatic void mismatch(input string what, input int unsigned want,
                                     input int unsigned got);
        err_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // check results and predict accepted items at the rising edge
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            tx_sum   <= '0;
            pay_idx  <= '0;
            read_cmd <= 1'b0;
            rx_ph    <= PH_WAIT;
            rx_sum   <= '0;
            rx_cnt   <= '0;
            rx_len   <= '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                             $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = due_results.pop_front();
                    if (m_axis_tuser !== want.kind)
                        mismatch("kind", want.kind, m_axis_tuser);
                    if (m_axis_tdata[7:0] !== want.byte_value)
                        mismatch("byte_value", want.byte_value, m_axis_tdata[7:0]);
                    if (m_axis_tdata[10:8] !== want.status)
                        mismatch("status", want.status, m_axis_tdata[10:8]);
                    if (m_axis_tdata[18:11] !== want.data_count)
                        mismatch("data_count", want.data_count, m_axis_tdata[18:11]);
                    if (m_axis_tdata[23:19] !== 5'd0)
                        mismatch("padding", 0, m_axis_tdata[23:19]);
                    if (m_axis_tlast !== want.last)
                        mismatch("last", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_link_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                                  s_axis_tlast);
                items_taken++;
            end
        end
    end

    // sender: offers queued items, idling at random
    always @(negedge i_clk) begin
        link_item_t it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (items_taken == items_offered) begin
            if (cmd_items.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
                it = cmd_items.pop_front();
                items_offered++;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= it.cmd;
                s_axis_tdata  <= {it.plen, it.data};
                s_axis_tlast  <= it.plast;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 27);
        end
    end

    task automatic add_item(input logic [1:0] cmd, input logic [7:0] data,
                            input logic [7:0] plen, input logic plast);
        link_item_t it;
        it.cmd   = cmd;
        it.data  = data;
        it.plen  = plen;
        it.plast = plast;
        cmd_items.push_back(it);
        items_queued++;
    endtask

    // received byte, with junk in the unused fields
    task automatic add_rx(input logic [7:0] b);
        add_item(CMD_RX, b, 8'($urandom), 1'($urandom));
    endtask

    // whole command of n payload bytes, opcode slot filled with op
    task automatic send_command(input int n, input logic [7:0] op, input logic [7:0] plen);
        for (int i = 0; i < n; i++)
            add_item(CMD_SEND, (i == 3) ? op : 8'($urandom), plen, i == n - 1);
    endtask

    // device reply to a read command: ack, length, and for an accepted length data and checksum
    task automatic send_reply(input logic [7:0] len_byte, input bit corrupt, input bit cut);
        logic [7:0] sum;
        logic [7:0] d;
        int         nd;
        add_rx(ACK_BYTE);
        add_rx(len_byte);
        if (len_byte == reply_len_cfg && len_byte >= MIN_REPLY_LEN) begin
            nd = len_byte - 3;
            if (cut)
                nd = $urandom_range(0, nd - 1);
            sum = ACK_BYTE + len_byte;
            for (int i = 0; i < nd; i++) begin
                d = $urandom;
                sum = sum + d;
                add_rx(d);
            end
            if (!cut)
                add_rx(corrupt ? sum + 8'($urandom_range(1, 255)) : sum);
        end
    endtask

    // one randomly shaped exchange, mostly well formed
    task automatic random_exchange;
        int         r;
        int         n;
        logic [7:0] op;
        logic [7:0] d;
        bit         is_read;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            case ($urandom_range(0, 3))
                0: op = OP_READ_D;
                1: op = OP_READ_R;
                2: op = OP_READ_N;
                default: op = $urandom;
            endcase
            send_command(n, op, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 252)) : 8'(n));
            is_read = n >= 4 && (op == OP_READ_D || op == OP_READ_R || op == OP_READ_N);
            // line noise before the ack
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    d = $urandom;
                    add_rx(d == ACK_BYTE ? 8'h07 : d);
                end
            end
            if ($urandom_range(0, 9) == 0)
                add_item(CMD_TIMEOUT, 8'($urandom), 8'($urandom), 1'($urandom));
            else if (is_read)
                send_reply(($urandom_range(0, 99) < 85) ? reply_len_cfg : 8'($urandom),
                           $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
            else
                add_rx(ACK_BYTE);
        end else if (r < 80) begin
            add_item(CMD_TIMEOUT, 8'($urandom), 8'($urandom), 1'($urandom));
        end else if (r < 90) begin
            add_rx(ACK_BYTE);
        end else begin
            add_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom_range(1, 252)),
                     $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic write_reply_len(input logic [7:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reply_len_cfg = v;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_link_idle;
        @(negedge i_clk);
        while (items_taken != items_queued || due_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // stimulus sequence
    initial begin
        int phase_start;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset reply length of 11
        add_item(CMD_SEND, 8'h00, 8'd1, 1'b1);
        add_rx(ACK_BYTE);
        add_item(CMD_TIMEOUT, 8'hFF, 8'hFF, 1'b1);
        add_item(2'd3, 8'hFF, 8'd252, 1'b1);
        add_item(CMD_SEND, 8'hFF, 8'd4, 1'b0);
        add_item(CMD_SEND, 8'h00, 8'd4, 1'b0);
        add_item(CMD_SEND, 8'h80, 8'd4, 1'b0);
        add_item(CMD_SEND, OP_READ_D, 8'd4, 1'b1);
        send_reply(8'd11, 1'b0, 1'b0);
        // stray ack re-arms the read, then a too-short length
        add_rx(ACK_BYTE);
        add_rx(8'd3);
        add_item(CMD_SEND, 8'hA5, 8'd252, 1'b1);
        wait_link_idle();

        // shortest reply length, no idling on either side
        write_reply_len(MIN_REPLY_LEN);
        steady = 1'b1;
        send_command(4, OP_READ_N, 8'd4);
        send_reply(MIN_REPLY_LEN, 1'b1, 1'b0);
        send_command(5, OP_READ_R, 8'd5);
        send_reply(8'd200, 1'b0, 1'b0);
        phase_start = items_queued;
        while (items_queued - phase_start < 15)
            random_exchange();
        wait_link_idle();
        steady = 1'b0;

        // longest reply length, and a command past the index limit
        write_reply_len(8'd255);
        send_command(257, OP_READ_R, 8'd252);
        add_rx(ACK_BYTE);
        add_rx(8'd254);
        wait_link_idle();

        // random reply length, receiver holds off at the start
        write_reply_len(8'($urandom_range(5, 40)));
        hold_req = 1'b1;
        phase_start = items_queued;
        while (items_queued - phase_start < 20)
            random_exchange();
        wait_link_idle();

        if (due_results.size() != 0) begin
            err_count++;
            $display("%0t: %0d results still expected at the end", $time, due_results.size());
        end
        $display("Run covered %0d input items and %0d results across %0d reply length writes",
                 items_taken, results_seen, cfg_writes);
        $display("with stalls on both sides, a long output hold-off and a 257 byte command");
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: sim.f
hdl/cfcl_pkg.sv
hdl/cfcl_core.sv
hdl/cfcl_out_buf.sv
hdl/checksummed_command_frame_link.sv
tb/checksummed_command_frame_link_tb.sv
